/* design/apmd_pkg.sv */
// Shared types, constants and the ramp step table for the angle PID drive.
package apmd_pkg;

  // Fixed-point formats
  localparam int ANGLE_FRAC_BITS = 4;
  localparam int GAIN_FRAC_BITS  = 16;
  localparam int REF_FRAC_BITS   = 8;
  localparam int REF_SHIFT       = REF_FRAC_BITS - ANGLE_FRAC_BITS;
  localparam int DEN_SHIFT       = GAIN_FRAC_BITS + ANGLE_FRAC_BITS;

  // Angle limits, Q4 degrees
  localparam int HALF_TURN  = 180 << ANGLE_FRAC_BITS;
  localparam int FULL_TURN  = 360 << ANGLE_FRAC_BITS;

  // 500 deg*s at 100 ticks/s, in Q4 degree-ticks
  localparam int INTEG_LIMIT = 500 * 100 * (1 << ANGLE_FRAC_BITS);

  localparam int OUT_LIMIT = 1000;
  localparam int TICK_RATE = 100;
  // Numerator that maps to full-scale output
  localparam longint OUT_LIMIT_NUM = longint'(OUT_LIMIT) * TICK_RATE * (longint'(1) << DEN_SHIFT);

  // Divide by TICK_RATE as multiply by reciprocal; exact for quotients up to 1996
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_100   = 167773;

  // Bridge direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_SETPOINT   = 3'd0;
  localparam logic [2:0] REG_RAMP_MODE  = 3'd1;
  localparam logic [2:0] REG_RAMP_SLOPE = 3'd2;
  localparam logic [2:0] REG_GAIN_P     = 3'd3;
  localparam logic [2:0] REG_GAIN_I     = 3'd4;
  localparam logic [2:0] REG_GAIN_D     = 3'd5;
  localparam logic [2:0] REG_STOP_BAND  = 3'd6;
  localparam logic [2:0] REG_MIN_DRIVE  = 3'd7;

  // Ramp step in Q8 degrees: round((1300 + 482*s) * 256 / 9900)
  localparam int SLOPE_MAX = 100;
  localparam int RAMP_DIV  = 9900;
  typedef logic [10:0] ramp_step_t;
  typedef ramp_step_t ramp_tab_t [0:SLOPE_MAX];

  function automatic ramp_tab_t build_ramp();
    ramp_tab_t tab;
    int        n;
    for (int s = 0; s <= SLOPE_MAX; s++) begin
      n      = (1300 + 482 * s) * 256;
      tab[s] = ramp_step_t'((n + RAMP_DIV / 2) / RAMP_DIV);
    end
    return tab;
  endfunction

  localparam ramp_tab_t RAMP_STEP = build_ramp();

  // Item leaving the state-update stage
  typedef struct packed {
    logic               en;
    logic               inband;
    logic signed [12:0] err;
    logic signed [20:0] isum;
    logic signed [13:0] diff;
  } front_t;

  // Item leaving the gain pipeline
  typedef struct packed {
    logic       en;
    logic       inband;
    logic       over;
    logic       pos;
    logic [9:0] q;
  } mag_t;

endpackage

/* design/angle_pid_motor_drive.sv */
// Top level of the angle PID motor drive: config registers, state loop, output stage.
//
// channel | direction | beat contents
// s_*     | in        | tdata[12:0] measured_angle, [13] enable, [15:14] zero
// m_*     | out       | tdata[9:0] drive_level, [11:10] direction,
//         |           |   [22:12] control_value, [23] zero
// APB     | in/out    | 8 registers at byte address 4*index, 32-bit data
//
// One beat in per cycle while s_tready is high, one result beat out per input beat, in order.
// The result beat is registered in order: the state update feeds the first
// pipe register at the input accept edge, five gain/scaling stages follow,
// the last one feeds the output register.
// The reference/integral/previous-error loop closes in the accept cycle.
// Stalls on m_tready ripple back through a per-stage valid chain, so
// bubbles are squeezed out before s_tready drops. Reset is synchronous
// and clears state, config to defaults, and all valids.
module angle_pid_motor_drive import apmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [12:0] measured_angle, [13] enable
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [9:0] drive_level, [11:10] direction, [22:12] control_value
  // Config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Config registers
  logic [12:0] setpoint;
  logic        ramp_mode;
  logic [6:0]  ramp_slope;
  logic [23:0] gain_p;
  logic [23:0] gain_i;
  logic [23:0] gain_d;
  logic [11:0] stop_band;
  logic [9:0]  min_drive;

  // Loop state
  logic [16:0]        reference;
  logic signed [20:0] integral;
  logic signed [12:0] prev_err;
  logic [1:0]         held_dir;
  logic signed [10:0] held_out;

  // Output register
  logic [9:0]         lvl;
  logic [1:0]         dir;
  logic signed [10:0] cv;

  logic        cfg_wr;
  logic [2:0]  reg_idx;
  logic        s_accept;
  logic        pipe_out_valid;
  logic        pipe_out_ready;
  logic        out_load;
  front_t      front;
  mag_t        po;

  // ---------------- Config port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint   <= 13'd1440;
      ramp_mode  <= 1'b0;
      ramp_slope <= 7'd0;
      gain_p     <= 24'd262144;
      gain_i     <= 24'd655;
      gain_d     <= 24'd6554;
      stop_band  <= 12'd16;
      min_drive  <= 10'd80;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SETPOINT:   setpoint   <= pwdata[12:0];
        REG_RAMP_MODE:  ramp_mode  <= pwdata[0];
        REG_RAMP_SLOPE: ramp_slope <= pwdata[6:0];
        REG_GAIN_P:     gain_p     <= pwdata[23:0];
        REG_GAIN_I:     gain_i     <= pwdata[23:0];
        REG_GAIN_D:     gain_d     <= pwdata[23:0];
        REG_STOP_BAND:  stop_band  <= pwdata[11:0];
        REG_MIN_DRIVE:  min_drive  <= pwdata[9:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SETPOINT:   prdata = 32'(setpoint);
      REG_RAMP_MODE:  prdata = 32'(ramp_mode);
      REG_RAMP_SLOPE: prdata = 32'(ramp_slope);
      REG_GAIN_P:     prdata = 32'(gain_p);
      REG_GAIN_I:     prdata = 32'(gain_i);
      REG_GAIN_D:     prdata = 32'(gain_d);
      REG_STOP_BAND:  prdata = 32'(stop_band);
      REG_MIN_DRIVE:  prdata = 32'(min_drive);
      default:        prdata = '0;
    endcase
  end

  // ---------------- Reference, error, integral ----------------
  logic [12:0]        meas;
  logic               en_in;
  logic [16:0]        spq;
  logic [6:0]         slope_sat;
  logic [17:0]        ramp_sum;
  logic [16:0]        ref_next;
  logic signed [13:0] e_raw;
  logic signed [13:0] e_wrap;
  logic signed [12:0] err;
  logic signed [21:0] sum_raw;
  logic signed [20:0] isum;
  logic [12:0]        err_mag;
  logic               inband;

  assign meas  = s_tdata[12:0];
  assign en_in = s_tdata[13];

  always_comb begin
    spq       = 17'(setpoint) << REF_SHIFT;
    slope_sat = (ramp_slope > 7'(SLOPE_MAX)) ? 7'(SLOPE_MAX) : ramp_slope;
    ramp_sum  = 18'(reference) + 18'(RAMP_STEP[slope_sat]);
    if (!ramp_mode) begin
      ref_next = spq;
    end else if (ramp_sum > 18'(spq)) begin
      ref_next = spq;
    end else begin
      ref_next = ramp_sum[16:0];
    end

    // Truncate reference to Q4 and wrap the error once into +-180 deg
    e_raw = $signed({1'b0, ref_next[REF_SHIFT +: 13]}) - $signed({1'b0, meas});
    if (e_raw > 14'(HALF_TURN)) begin
      e_wrap = e_raw - 14'(FULL_TURN);
    end else if (e_raw < -14'(HALF_TURN)) begin
      e_wrap = e_raw + 14'(FULL_TURN);
    end else begin
      e_wrap = e_raw;
    end
    err = e_wrap[12:0];

    sum_raw = 22'(integral) + 22'(err);
    if (sum_raw > 22'(INTEG_LIMIT)) begin
      isum = 21'(INTEG_LIMIT);
    end else if (sum_raw < -22'(INTEG_LIMIT)) begin
      isum = -21'(INTEG_LIMIT);
    end else begin
      isum = sum_raw[20:0];
    end

    err_mag = err[12] ? 13'(-err) : 13'(err);
    inband  = err_mag <= {1'b0, stop_band};

    front.en     = en_in;
    front.inband = inband;
    front.err    = err;
    front.isum   = isum;
    front.diff   = 14'(err) - 14'(prev_err);
  end

  assign s_accept = s_tvalid && s_tready;

  // Loop state moves only on enabled ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      reference <= '0;
      integral  <= '0;
      prev_err  <= '0;
    end else if (s_accept && en_in) begin
      reference <= ref_next;
      integral  <= inband ? '0 : isum;
      prev_err  <= err;
    end
  end

  // ---------------- Gain pipeline ----------------
  apmd_gain_pipe u_gain (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (front),
    .gain_p    (gain_p),
    .gain_i    (gain_i),
    .gain_d    (gain_d),
    .out_valid (pipe_out_valid),
    .out_ready (pipe_out_ready),
    .out_item  (po)
  );

  // ---------------- Output stage ----------------
  logic [9:0]         mag;
  logic [9:0]         mind;
  logic [9:0]         vmag;
  logic signed [10:0] val;
  logic [1:0]         dir_new;

  always_comb begin
    mag  = po.over ? 10'(OUT_LIMIT) : po.q;
    mind = (min_drive > 10'(OUT_LIMIT)) ? 10'(OUT_LIMIT) : min_drive;
    // Stop band forces zero; otherwise lift small outputs to the minimum
    if (po.inband) begin
      vmag = '0;
    end else if (mag < mind) begin
      vmag = mind;
    end else begin
      vmag = mag;
    end
    // Exact zero numerator lifted to the minimum goes counterclockwise
    val = po.pos ? $signed(11'(vmag)) : -$signed(11'(vmag));
    if (po.inband) begin
      dir_new = DIR_STOP;
    end else if (vmag == '0) begin
      dir_new = held_dir;
    end else begin
      dir_new = po.pos ? DIR_CW : DIR_CCW;
    end
  end

  assign pipe_out_ready = !m_tvalid || m_tready;
  assign out_load       = pipe_out_valid && pipe_out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      held_dir <= DIR_STOP;
      held_out <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (out_load && po.en) begin
        held_dir <= dir_new;
        held_out <= val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (po.en) begin
        lvl <= vmag;
        dir <= dir_new;
        cv  <= val;
      end else begin
        // Disabled tick: no drive, repeat last direction and output
        lvl <= '0;
        dir <= held_dir;
        cv  <= held_out;
      end
    end
  end

  assign m_tdata = {1'b0, cv, dir, lvl};

  // ---------------- Checks ----------------
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (lvl <= 10'(OUT_LIMIT)))
    else $error("drive level above limit");

  a_level_sign: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (lvl != '0)) |->
      ((dir == DIR_CW) && (cv > 0)) || ((dir == DIR_CCW) && (cv < 0)))
    else $error("nonzero drive level disagrees with direction or sign");

  a_integral_clamp: assert property (@(posedge clk) disable iff (rst)
    (integral <= 21'(INTEG_LIMIT)) && (integral >= -21'(INTEG_LIMIT)))
    else $error("integral outside clamp");

  a_ref_below_setpoint: assert property (@(posedge clk) disable iff (rst)
    (s_accept && en_in && !cfg_wr) |=> (reference <= (17'(setpoint) << REF_SHIFT)))
    else $error("reference passed setpoint");

endmodule

/* design/apmd_gain_pipe.sv */
// PID gain products, sum and scaling to output units, six registered stages.
module apmd_gain_pipe import apmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  front_t      in_item,
  input  logic [23:0] gain_p,
  input  logic [23:0] gain_i,
  input  logic [23:0] gain_d,
  output logic        out_valid,
  input  logic        out_ready,
  output mag_t        out_item
);

  localparam int NSTG = 6;

  logic [NSTG:1] v;
  logic [NSTG:1] rdy;
  logic [NSTG:1] en_s;
  logic [NSTG:1] ib_s;

  // Stage payloads
  front_t             f1;
  logic signed [37:0] pp2;
  logic signed [45:0] ip2;
  logic signed [38:0] dp2;
  logic signed [44:0] p3;
  logic signed [45:0] i3;
  logic signed [52:0] d3;
  logic signed [53:0] num4;
  logic signed [53:0] abs5;
  logic [16:0]        t5;
  logic               over5;
  logic               pos5;
  logic               over6;
  logic               pos6;
  logic [9:0]         q6;
  logic [34:0]        qprod;

  // A stage can load when empty or when it moves on this cycle
  always_comb begin
    rdy[NSTG] = !v[NSTG] || out_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      en_s[1] <= in_item.en;
      ib_s[1] <= in_item.inband;
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (rdy[k]) begin
        en_s[k] <= en_s[k-1];
        ib_s[k] <= ib_s[k-1];
      end
    end
  end

  assign abs5  = num4[53] ? -num4 : num4;
  assign qprod = 35'(t5) * 35'(RECIP_100);

  always_ff @(posedge clk) begin
    if (rdy[1]) f1 <= in_item;
    if (rdy[2]) begin
      pp2 <= $signed({1'b0, gain_p}) * f1.err;
      ip2 <= $signed({1'b0, gain_i}) * f1.isum;
      dp2 <= $signed({1'b0, gain_d}) * f1.diff;
    end
    if (rdy[3]) begin
      p3 <= 45'(pp2) * 45'sd100;
      i3 <= ip2;
      d3 <= 53'(dp2) * 53'sd10000;
    end
    if (rdy[4]) num4 <= 54'(p3) + 54'(i3) + 54'(d3);
    if (rdy[5]) begin
      over5 <= abs5 > 54'(OUT_LIMIT_NUM);
      pos5  <= !num4[53] && (num4 != '0);
      t5    <= abs5[DEN_SHIFT +: 17];
    end
    if (rdy[6]) begin
      over6 <= over5;
      pos6  <= pos5;
      q6    <= qprod[RECIP_SHIFT +: 10];
    end
  end

  assign out_valid = v[NSTG];
  assign out_item  = '{en: en_s[NSTG], inband: ib_s[NSTG], over: over6, pos: pos6, q: q6};

endmodule
